[rtl/ilst_pkg.sv]
// ----------------------------------------------------------------------------
// ilst_pkg: shared types and constants for the indexed insert/remove list
// Request/response structs, operation and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package ilst_pkg;

    localparam int Depth    = 64;
    localparam int WordBits = 32;

    localparam int OpBits   = 3;
    localparam int PosBits  = 7;
    localparam int ValBits  = 32;
    localparam int StatBits = 2;
    localparam int CntOBits = 7;

    // internal widths
    localparam int CntBits  = $clog2(Depth + 1);
    localparam int CmpBits  = (CntBits > PosBits) ? CntBits : PosBits;

    typedef enum logic [OpBits-1:0] {
        OP_INSERT = 3'd0,
        OP_APPEND = 3'd1,
        OP_REMOVE = 3'd2,
        OP_TAKE   = 3'd3,
        OP_PEEK   = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [StatBits-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_NULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [OpBits-1:0]  operation;
        logic [PosBits-1:0] position;
        logic [ValBits-1:0] value;
    } t_req;

    typedef struct packed {
        logic [ValBits-1:0]  data_out;
        logic [StatBits-1:0] status;
        logic [CntOBits-1:0] count_out;
    } t_rsp;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                ins;
        logic                rem;
        logic [CmpBits-1:0]  pos;
        logic [WordBits-1:0] word;
    } t_cell_ctl;

endpackage

[rtl/ilst_cell.sv]
// ----------------------------------------------------------------------------
// ilst_cell: one storage slot of the list chain
// Holds one word; shifts from its lower or upper neighbor, or loads the new
// word, and drives its word onto the read bus when addressed.
// ----------------------------------------------------------------------------
module ilst_cell
    import ilst_pkg::*;
(
    input  logic                i_clk,
    input  logic [CmpBits-1:0]  i_index,
    input  t_cell_ctl           i_ctl,
    input  logic [WordBits-1:0] i_lower,
    input  logic [WordBits-1:0] i_upper,
    output logic [WordBits-1:0] o_word,
    output logic [WordBits-1:0] o_sel_word
);

    logic [WordBits-1:0] r_word;
    logic [WordBits-1:0] n_word;
    logic                at_pos;
    logic                above_pos;

    assign at_pos    = (i_index == i_ctl.pos);
    assign above_pos = (i_index > i_ctl.pos);

    always_comb begin
        n_word = r_word;
        if (i_ctl.ins) begin
            if (at_pos) begin
                n_word = i_ctl.word;
            end else if (above_pos) begin
                n_word = i_lower;
            end
        end else if (i_ctl.rem) begin
            if (at_pos || above_pos) begin
                n_word = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    assign o_sel_word = at_pos ? r_word : '0;

endmodule

[rtl/indexed_insert_remove_list_unit.sv]
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_unit: ordered list with indexed insert/remove
// The response is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the output is not stalled; all cells shift in parallel on the same edge.
// The response register accepts a new request while the old one is taken.
// Reset (i_rst_n low, synchronous) empties the list and drops the response;
// cell storage is not cleared, only positions below the count are read.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_unit
    import ilst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    logic [CntBits-1:0] r_count;
    logic [CntBits-1:0] n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    t_rsp               r_rsp;
    t_rsp               n_rsp;

    // ------------------------------------------------------------------
    // Handshake: the response register frees up when it is taken, so a
    // new request goes in the same cycle the old response leaves.
    // ------------------------------------------------------------------
    logic accept;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic [WordBits-1:0] word;
    logic [CmpBits-1:0]  req_pos;
    logic [CmpBits-1:0]  cnt_ext;
    logic [CmpBits-1:0]  eff_pos;
    logic                do_ins;
    logic                do_rem;
    t_status             status;
    logic [WordBits-1:0] bus_word;
    logic [ValBits-1:0]  rd_data;

    assign word    = WordBits'(i_in_req.value);
    assign req_pos = CmpBits'(i_in_req.position);
    assign cnt_ext = CmpBits'(r_count);

    always_comb begin
        eff_pos = req_pos;
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        status  = ST_OK;
        rd_data = '0;
        n_count = r_count;
        case (i_in_req.operation)
            OP_INSERT, OP_APPEND: begin
                if (i_in_req.operation == OP_APPEND) begin
                    eff_pos = cnt_ext;
                end
                if (word == '0) begin
                    status = ST_NULL;
                end else if (eff_pos > cnt_ext) begin
                    status = ST_RANGE;
                end else if (cnt_ext == CmpBits'(Depth)) begin
                    status = ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + CntBits'(1);
                end
            end
            OP_REMOVE, OP_TAKE: begin
                if (i_in_req.operation == OP_TAKE) begin
                    eff_pos = '0;
                end
                if (eff_pos >= cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    do_rem  = 1'b1;
                    rd_data = ValBits'(bus_word);
                    n_count = r_count - CntBits'(1);
                end
            end
            OP_PEEK: begin
                if (eff_pos >= cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    rd_data = ValBits'(bus_word);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unused codes: no effect
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Cell chain: cell i holds list position i. Insert shifts cells
    // above the position up from their lower neighbor; remove shifts
    // cells at and above the position down from their upper neighbor.
    // ------------------------------------------------------------------
    t_cell_ctl           cell_ctl;
    logic [WordBits-1:0] cell_word [Depth];
    logic [WordBits-1:0] cell_sel  [Depth];

    assign cell_ctl.ins  = accept && do_ins;
    assign cell_ctl.rem  = accept && do_rem;
    assign cell_ctl.pos  = eff_pos;
    assign cell_ctl.word = word;

    for (genvar g = 0; g < Depth; g++) begin : g_cell
        logic [WordBits-1:0] lower;
        logic [WordBits-1:0] upper;
        if (g == 0) begin : g_first
            assign lower = '0;
        end else begin : g_mid_lo
            assign lower = cell_word[g-1];
        end
        if (g == Depth - 1) begin : g_last
            assign upper = '0;
        end else begin : g_mid_hi
            assign upper = cell_word[g+1];
        end
        ilst_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (CmpBits'(g)),
            .i_ctl      (cell_ctl),
            .i_lower    (lower),
            .i_upper    (upper),
            .o_word     (cell_word[g]),
            .o_sel_word (cell_sel[g])
        );
    end

    // read bus: only the addressed cell drives non-zero
    always_comb begin
        bus_word = '0;
        for (int k = 0; k < Depth; k++) begin
            bus_word = bus_word | cell_sel[k];
        end
    end

    // ------------------------------------------------------------------
    // Response register and count
    // ------------------------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_rsp       = r_rsp;
        if (accept) begin
            n_out_valid     = 1'b1;
            n_rsp.data_out  = rd_data;
            n_rsp.status    = status;
            n_rsp.count_out = CntOBits'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            r_out_valid <= n_out_valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for indexed_insert_remove_list_unit
// Runs directed corner cases, a fill-to-full pass, random traffic with
// random gaps on both sides, a back-to-back pass and one long output hold-off.
// A shadow copy of the list predicts each response, and the responses are compared in order.
// ----------------------------------------------------------------------------
module tb_top
    import ilst_pkg::*;
;

    // opcodes the block does not decode; they must leave the list alone
    localparam logic [OpBits-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OpBits-1:0] OP_RSVD_7 = 3'd7;

    localparam int HoldCycles  = 60;      // long receiver hold-off
    localparam int DrainCycles = 4;       // quiet cycles after the last response
    localparam int CycleLimit  = 400000;  // watchdog

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_req i_in_req;
    logic o_out_valid;
    logic i_out_stall;
    t_rsp o_out_rsp;

    // shadow of the list contents, head at index 0
    logic [WordBits-1:0] shadow_list[$];
    // responses predicted but not yet seen
    t_rsp                expected_rsps[$];

    int n_sent;
    int n_checked;
    int n_errors;
    int status_seen[4];
    int cycle_count;

    bit quiet_mode;    // no gaps on either side while set
    bit hold_request;  // asks the stall process for one long hold-off

    indexed_insert_remove_list_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Shadow list: applies one request and returns the response it must give.
    // Null check first, then position, then full, as the block orders them.
    // ------------------------------------------------------------------------
    function automatic t_rsp predict_list_op(t_req req);
        t_rsp rsp;
        int   pos;
        rsp        = '0;
        rsp.status = ST_OK;
        pos        = int'(req.position);
        case (req.operation)
            OP_INSERT, OP_APPEND: begin
                if (req.operation == OP_APPEND)
                    pos = shadow_list.size();
                if (req.value == '0)
                    rsp.status = ST_NULL;
                else if (pos > shadow_list.size())
                    rsp.status = ST_RANGE;
                else if (shadow_list.size() >= Depth)
                    rsp.status = ST_FULL;
                else
                    shadow_list.insert(pos, req.value);
            end
            OP_REMOVE, OP_TAKE: begin
                if (req.operation == OP_TAKE)
                    pos = 0;
                if (pos >= shadow_list.size()) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.data_out = shadow_list[pos];
                    shadow_list.delete(pos);
                end
            end
            OP_PEEK: begin
                if (pos >= shadow_list.size())
                    rsp.status = ST_RANGE;
                else
                    rsp.data_out = shadow_list[pos];
            end
            OP_CLEAR: begin
                shadow_list.delete();
            end
            default: ;  // unused opcodes: no effect
        endcase
        rsp.count_out = CntOBits'(shadow_list.size());
        return rsp;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 2);
        else if (roll < 97)
            return $urandom_range(3, 6);
        else
            return $urandom_range(10, 30);
    endfunction

    function automatic logic [ValBits-1:0] nonzero_word();
        logic [ValBits-1:0] w;
        do
            w = $urandom;
        while (w == '0);
        return w;
    endfunction

    function automatic t_req make_req(logic [OpBits-1:0] op, int pos,
                                      logic [ValBits-1:0] val);
        t_req req;
        req.operation = op;
        req.position  = PosBits'(pos);
        req.value     = val;
        return req;
    endfunction

    // Random request. insert_pct sets the share of inserts/appends and so
    // whether the list tends to grow or drain. Positions mostly fall in or
    // just past the list; some cover the whole 7-bit field.
    function automatic t_req random_request(int insert_pct);
        t_req req;
        int   roll;
        int   cnt;
        int   vroll;
        roll = $urandom_range(0, 999);
        cnt  = shadow_list.size();
        if (roll < insert_pct * 10) begin
            req.operation = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_APPEND;
        end else if (roll < 980) begin
            case ($urandom_range(0, 2))
                0:       req.operation = OP_REMOVE;
                1:       req.operation = OP_TAKE;
                default: req.operation = OP_PEEK;
            endcase
        end else if (roll < 985) begin
            req.operation = OP_CLEAR;
        end else begin
            req.operation = ($urandom_range(0, 1) == 0) ? OP_RSVD_6 : OP_RSVD_7;
        end
        if ($urandom_range(0, 5) == 0)
            req.position = PosBits'($urandom_range(0, 127));
        else
            req.position = PosBits'($urandom_range(0, cnt));
        vroll = $urandom_range(0, 99);
        if (vroll < 3)
            req.value = '0;
        else if (vroll < 6)
            req.value = '1;
        else
            req.value = $urandom;
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Send one request: optional idle gap, then hold valid and payload until
    // the block takes it. Valid stays high on exit so back-to-back requests
    // need no extra edge. The prediction is made at acceptance.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_req req);
        int gap;
        gap = quiet_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do
            @(posedge i_clk);
        while (o_in_stall);
        expected_rsps.push_back(predict_list_op(req));
        n_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall: free and stalled runs of random length, mostly free.
    // A hold request forces one long stall, counted down here.
    // ------------------------------------------------------------------------
    initial begin : rsp_stall_gen
        int   left;
        logic stall_next;
        left        = 0;
        stall_next  = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_next   = 1'b1;
                left         = HoldCycles;
            end else if (left > 0) begin
                left--;
            end else if (quiet_mode || $urandom_range(0, 2) != 0) begin
                stall_next = 1'b0;
                left       = quiet_mode ? 0 : pick_gap();
            end else begin
                stall_next = 1'b1;
                left       = pick_gap();
            end
            i_out_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------------
    // Response checker: every accepted response against the oldest prediction.
    // ------------------------------------------------------------------------
    initial begin : rsp_checker
        t_rsp want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (expected_rsps.size() == 0) begin
                    $error("response with none pending: data_out %h status %0d count_out %0d",
                           o_out_rsp.data_out, o_out_rsp.status, o_out_rsp.count_out);
                    n_errors++;
                end else begin
                    want = expected_rsps.pop_front();
                    status_seen[want.status]++;
                    n_checked++;
                    if (o_out_rsp.data_out !== want.data_out) begin
                        $error("data_out mismatch: expected %h, got %h",
                               want.data_out, o_out_rsp.data_out);
                        n_errors++;
                    end
                    if (o_out_rsp.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, o_out_rsp.status);
                        n_errors++;
                    end
                    if (o_out_rsp.count_out !== want.count_out) begin
                        $error("count_out mismatch: expected %0d, got %0d",
                               want.count_out, o_out_rsp.count_out);
                        n_errors++;
                    end
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty list: every read-side op is out of range, null words are
    // rejected, a position past the tail is refused, unused opcodes idle.
    task automatic test_empty_and_null();
        send_request(make_req(OP_TAKE,   0, '0));
        send_request(make_req(OP_REMOVE, 0, '0));
        send_request(make_req(OP_PEEK,   0, '0));
        send_request(make_req(OP_INSERT, 0, '0));
        send_request(make_req(OP_APPEND, 0, '0));
        send_request(make_req(OP_INSERT, 1, 32'h0000_0005));
        send_request(make_req(OP_RSVD_6, 127, '1));
        send_request(make_req(OP_RSVD_7, 0, '0));
        send_request(make_req(OP_CLEAR,  0, '0));
    endtask

    // Insert at head, middle and tail, extreme words, peeks and removes at
    // both ends and the middle, position field all ones, then clear.
    task automatic test_edges();
        send_request(make_req(OP_INSERT, 0, 32'hFFFF_FFFF));  // into empty list
        send_request(make_req(OP_APPEND, 0, 32'h0000_0001));
        send_request(make_req(OP_INSERT, 1, 32'h8000_0000));  // middle
        send_request(make_req(OP_INSERT, 3, 32'h5555_AAAA));  // position == count
        send_request(make_req(OP_INSERT, 0, 32'hAAAA_5555));  // head
        send_request(make_req(OP_INSERT, 6, 32'h0000_0007));  // past tail
        send_request(make_req(OP_PEEK,   127, '0));
        send_request(make_req(OP_PEEK,   4, '0));
        send_request(make_req(OP_PEEK,   0, '0));
        send_request(make_req(OP_REMOVE, 2, '0));
        send_request(make_req(OP_REMOVE, 3, '0));              // last entry
        send_request(make_req(OP_REMOVE, 3, '0));              // now past the end
        send_request(make_req(OP_TAKE,   0, '0));
        send_request(make_req(OP_RSVD_6, 0, 32'h1234_5678));  // non-empty list
        send_request(make_req(OP_CLEAR,  0, '0));
    endtask

    // Fill to Depth, hit full from every angle (null and range take
    // priority), work the last slot, then drain with random removes.
    task automatic test_full_list();
        while (shadow_list.size() < Depth)
            send_request(make_req(OP_APPEND, 0, nonzero_word()));
        send_request(make_req(OP_APPEND, 0, nonzero_word()));
        send_request(make_req(OP_INSERT, Depth, nonzero_word()));
        send_request(make_req(OP_INSERT, 0, nonzero_word()));
        send_request(make_req(OP_INSERT, Depth + 1, nonzero_word()));
        send_request(make_req(OP_APPEND, 0, '0));
        send_request(make_req(OP_PEEK,   Depth - 1, '0));
        send_request(make_req(OP_PEEK,   Depth, '0));
        send_request(make_req(OP_REMOVE, Depth - 1, '0));
        send_request(make_req(OP_INSERT, Depth / 3, nonzero_word()));
        while (shadow_list.size() > 0)
            send_request(make_req(OP_REMOVE,
                                  $urandom_range(0, shadow_list.size() - 1), '0));
    endtask

    // Alternate growing and draining phases so the list sweeps its whole
    // range, then a long balanced stretch.
    task automatic test_random_traffic();
        for (int round = 0; round < 3; round++) begin
            repeat (150) send_request(random_request(80));
            repeat (150) send_request(random_request(25));
        end
        repeat (600) send_request(random_request(50));
    endtask

    // No gaps on either side: one request and one response every cycle once any stall run under way has ended.
    task automatic test_back_to_back();
        quiet_mode = 1'b1;
        repeat (200) send_request(random_request(55));
        quiet_mode = 1'b0;
    endtask

    // Receiver holds off for a long stretch while requests keep coming, so
    // the response register fills and the input stalls.
    task automatic test_output_hold_off();
        quiet_mode   = 1'b1;
        hold_request = 1'b1;
        repeat (16) send_request(random_request(60));
        quiet_mode   = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        n_sent       = 0;
        n_checked    = 0;
        n_errors     = 0;
        quiet_mode   = 1'b0;
        hold_request = 1'b0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in_req     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_null();
        test_edges();
        test_full_list();
        test_random_traffic();
        test_back_to_back();
        test_output_hold_off();

        i_in_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("%0d requests sent, %0d responses checked in %0d cycles",
                 n_sent, n_checked, cycle_count);
        $display("status mix: %0d ok, %0d full, %0d out of range, %0d null rejected",
                 status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_RANGE], status_seen[ST_NULL]);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ilst_pkg.sv
rtl/ilst_cell.sv
rtl/indexed_insert_remove_list_unit.sv
bench/tb_top.sv
